@@ hdl/frame_ring_buffer_drop_oldest_core_defines.svh @@
// Assertion macros for the frame ring buffer core.
`ifndef FRAME_RING_BUFFER_DROP_OLDEST_CORE_DEFINES_SVH
`define FRAME_RING_BUFFER_DROP_OLDEST_CORE_DEFINES_SVH
// Check a property on the rising clock, disabled during reset.
`define FRB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on the rising clock at all times.
`define FRB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hdl/frbdo_pkg.sv @@
// Package: types, codes and constants of the frame ring buffer core.
`default_nettype none
package frbdo_pkg;
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int MAX_FRAMES_DEF   = 16;
    localparam int SIZE_W           = 13;
    localparam int STAMP_W          = 32;

    localparam logic [1:0] CMD_BEGIN_PUT = 2'd0;
    localparam logic [1:0] CMD_PUT_BYTE  = 2'd1;
    localparam logic [1:0] CMD_BEGIN_GET = 2'd2;
    localparam logic [1:0] CMD_GET_BYTE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_ROOM   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_SEQUENCE  = 3'd4;

    localparam logic CFG_EVICTION_LIMIT = 1'b0;
    localparam logic CFG_FRAME_LIMIT    = 1'b1;

    localparam logic [7:0] EVICTION_LIMIT_RST = 8'd50;
    localparam logic [4:0] FRAME_LIMIT_RST    = 5'd16;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } frame_rec_t;
endpackage
`default_nettype wire

@@ hdl/frame_ring_buffer_drop_oldest_core.sv @@
// Top level: variable-length frame ring buffer that drops the oldest frames.
`default_nettype none
`include "frame_ring_buffer_drop_oldest_core_defines.svh"
// Frames are stored byte by byte in a circular memory of BUFFER_BYTES bytes;
// a queue of up to MAX_FRAMES (size, timestamp) records tracks them, oldest
// first. Each input beat is one command (begin put, put byte, begin get, get
// byte) and yields exactly one result beat with status and occupancy. The
// block handles one command at a time. Put byte, begin get, too-large begin
// put and sequence errors go straight to the result state S_OUT; get byte
// issues the byte memory read as it is taken, passes S_RDWT, captures the
// registered data in S_RDCAP and presents it in S_OUT; a begin put that fits
// passes S_EVICT, where it drops oldest frames while it lacks room, and
// S_LIMIT, where it drops oldest frames until fewer than frame_limit are held,
// before it opens or commits its frame, and one that finds no room goes from
// S_EVICT to S_OUT. The drop sequencer pops one record per cycle through a single
// shared subtract/compare unit and never drops more frames than are held, and
// a result waits in S_OUT, holding the block, for as long as m_tready is low.
// The result sits in an output register; the next command is taken once it
// is delivered. BUFFER_BYTES must be a power of two (ring pointers wrap by
// truncation) and no larger than 4096, and MAX_FRAMES no larger than 16, so
// that sizes, counts and free space fit their result fields. Configuration
// writes (index 0 eviction_limit, 1 frame_limit) are taken at any time and
// are meant to arrive while the block is idle.
module frame_ring_buffer_drop_oldest_core #(
    parameter int BUFFER_BYTES = frbdo_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_FRAMES   = frbdo_pkg::MAX_FRAMES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[1:0], data_byte[9:2], frame_size[22:10], timestamp[54:23], pad
    input  wire logic [55:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0], read_byte[10:3], size_out[23:11], timestamp_out[55:24],
    // frames_dropped[60:56], frames_held[65:61], free_bytes[78:66], pad
    output logic [79:0]       m_tdata,
    // last_byte
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [7:0]   cfg_data
);
    import frbdo_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int QW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [SIZE_W:0] BUF_SZ = (SIZE_W+1)'(BUFFER_BYTES);
    localparam logic [8:0] MAXF = 9'(MAX_FRAMES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVICT = 3'd1;
    localparam logic [2:0] S_LIMIT = 3'd2;
    localparam logic [2:0] S_RDWT  = 3'd3;
    localparam logic [2:0] S_RDCAP = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        evict_lim_reg;
    logic [4:0]        frame_lim_reg;
    logic [AW-1:0]     rptr_reg, wptr_reg;
    logic [SIZE_W:0]   used_reg;
    logic [QW-1:0]     head_reg, tail_reg;
    logic [8:0]        count_reg;
    frame_rec_t        pend_reg;
    logic [SIZE_W-1:0] put_rem_reg, get_rem_reg;
    logic              put_open_reg, get_open_reg;
    logic [7:0]        tries_reg;
    logic [4:0]        dropped_reg;
    logic [2:0]        status_reg;
    logic [7:0]        rbyte_reg;
    logic              last_reg;
    frame_rec_t        rec_out_reg;
    frame_rec_t        queue [MAX_FRAMES];
    frame_rec_t        head_rec;
    logic [7:0]        ram_q;

    logic [1:0]        in_cmd;
    logic [7:0]        in_data;
    logic [SIZE_W-1:0] in_size;
    logic [STAMP_W-1:0] in_stamp;
    logic              take;
    logic [SIZE_W:0]   free_now;
    logic [8:0]        lim_eff;
    logic              seq_err;

    assign in_cmd   = s_tdata[1:0];
    assign in_data  = s_tdata[9:2];
    assign in_size  = s_tdata[22:10];
    assign in_stamp = s_tdata[54:23];
    assign take     = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign free_now = BUF_SZ - used_reg;
    assign head_rec = queue[head_reg];

    // Clamp frame_limit into 1..MAX_FRAMES.
    always_comb begin
        lim_eff = 9'(frame_lim_reg);
        if (lim_eff == 9'd0) lim_eff = 9'd1;
        if (lim_eff > MAXF) lim_eff = MAXF;
    end

    assign seq_err = (put_open_reg && in_cmd != CMD_PUT_BYTE) ||
                     (get_open_reg && in_cmd != CMD_GET_BYTE) ||
                     (in_cmd == CMD_PUT_BYTE && !put_open_reg) ||
                     (in_cmd == CMD_GET_BYTE && !get_open_reg);

    function automatic logic [QW-1:0] nxt(input logic [QW-1:0] i);
        logic [QW-1:0] r;
        r = (32'(i) + 1 >= MAX_FRAMES) ? '0 : i + 1'b1;
        return r;
    endfunction

    // Shared drop unit: subtract the head frame size from the used count.
    logic [SIZE_W:0] used_after_drop;
    logic [AW-1:0]   rptr_after_drop;
    assign used_after_drop = (used_reg >= {1'b0, head_rec.size}) ?
                             used_reg - {1'b0, head_rec.size} : '0;
    // Wrap at the ring size by keeping the low address bits.
    assign rptr_after_drop = AW'(32'(rptr_reg) + 32'(head_rec.size));

    logic ram_we, ram_re;
    assign ram_we = take && !seq_err && in_cmd == CMD_PUT_BYTE;
    assign ram_re = take && !seq_err && in_cmd == CMD_GET_BYTE;

    frbdo_ram #(.DEPTH(BUFFER_BYTES), .AW(AW)) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(wptr_reg),
        .wr_data(in_data),
        .rd_en  (ram_re),
        .rd_addr(rptr_reg),
        .rd_data(ram_q)
    );

    logic do_push;
    logic do_pop;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    if (seq_err) state_next = S_OUT;
                    else if (in_cmd == CMD_BEGIN_PUT && 32'(in_size) <= BUFFER_BYTES)
                        state_next = S_EVICT;
                    else if (in_cmd == CMD_GET_BYTE) state_next = S_RDWT;
                    else state_next = S_OUT;
                end
            end
            S_EVICT: begin
                if (!(free_now < {1'b0, pend_reg.size} && tries_reg < evict_lim_reg &&
                      count_reg != 9'd0)) begin
                    state_next = (free_now < {1'b0, pend_reg.size}) ? S_OUT : S_LIMIT;
                end
            end
            S_LIMIT: begin
                if (!(count_reg >= lim_eff && count_reg != 9'd0)) state_next = S_OUT;
            end
            S_RDWT:  state_next = S_RDCAP;
            S_RDCAP: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign do_push = (take && !seq_err && in_cmd == CMD_PUT_BYTE && put_rem_reg == 13'd1) ||
                     (state_reg == S_LIMIT && !(count_reg >= lim_eff && count_reg != 9'd0) &&
                      pend_reg.size == '0);
    assign do_pop = (state_reg == S_EVICT && free_now < {1'b0, pend_reg.size} &&
                     tries_reg < evict_lim_reg && count_reg != 9'd0) ||
                    (state_reg == S_LIMIT && count_reg >= lim_eff && count_reg != 9'd0) ||
                    (take && !seq_err && in_cmd == CMD_BEGIN_GET && count_reg != 9'd0);

    always_ff @(posedge aclk) begin
        if (do_push) queue[tail_reg] <= pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            evict_lim_reg <= EVICTION_LIMIT_RST;
            frame_lim_reg <= FRAME_LIMIT_RST;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            used_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= '0;
            put_rem_reg   <= '0;
            get_rem_reg   <= '0;
            put_open_reg  <= 1'b0;
            get_open_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_EVICTION_LIMIT: evict_lim_reg <= cfg_data;
                    CFG_FRAME_LIMIT:    frame_lim_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (do_push) begin
                tail_reg <= nxt(tail_reg);
            end
            if (do_pop) begin
                head_reg <= nxt(head_reg);
            end
            if (do_push && !do_pop) count_reg <= count_reg + 9'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 9'd1;
            // Drops also release the frame's bytes.
            if (state_reg == S_EVICT || state_reg == S_LIMIT) begin
                if (do_pop) begin
                    used_reg <= used_after_drop;
                    rptr_reg <= rptr_after_drop;
                end
                if (state_reg == S_LIMIT && state_next == S_OUT && pend_reg.size != '0) begin
                    put_rem_reg  <= pend_reg.size;
                    put_open_reg <= 1'b1;
                end
            end
            if (take && !seq_err) begin
                unique case (in_cmd)
                    CMD_BEGIN_PUT: begin
                        pend_reg.size  <= in_size;
                        pend_reg.stamp <= in_stamp;
                    end
                    CMD_PUT_BYTE: begin
                        wptr_reg <= wptr_reg + 1'b1;
                        if (used_reg < BUF_SZ) used_reg <= used_reg + 1'b1;
                        put_rem_reg <= put_rem_reg - 1'b1;
                        if (put_rem_reg == 13'd1) put_open_reg <= 1'b0;
                    end
                    CMD_BEGIN_GET: begin
                        if (count_reg != 9'd0) begin
                            get_rem_reg  <= head_rec.size;
                            get_open_reg <= (head_rec.size != '0);
                        end
                    end
                    CMD_GET_BYTE: begin
                        rptr_reg <= rptr_reg + 1'b1;
                        if (used_reg != '0) used_reg <= used_reg - 1'b1;
                        get_rem_reg <= get_rem_reg - 1'b1;
                        if (get_rem_reg == 13'd1) get_open_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (take) begin
            tries_reg   <= '0;
            dropped_reg <= '0;
            rbyte_reg   <= '0;
            last_reg    <= 1'b0;
            rec_out_reg <= '0;
            if (seq_err) status_reg <= ST_SEQUENCE;
            else if (in_cmd == CMD_BEGIN_PUT && 32'(in_size) > BUFFER_BYTES)
                status_reg <= ST_TOO_LARGE;
            else if (in_cmd == CMD_BEGIN_GET && count_reg == 9'd0)
                status_reg <= ST_EMPTY;
            else status_reg <= ST_OK;
            if (!seq_err && in_cmd == CMD_BEGIN_GET && count_reg != 9'd0)
                rec_out_reg <= head_rec;
            if (!seq_err && in_cmd == CMD_GET_BYTE) last_reg <= (get_rem_reg == 13'd1);
        end
        if (state_reg == S_EVICT && do_pop) tries_reg <= tries_reg + 1'b1;
        if ((state_reg == S_EVICT || state_reg == S_LIMIT) && do_pop)
            dropped_reg <= dropped_reg + 1'b1;
        if (state_reg == S_EVICT && state_next == S_OUT) status_reg <= ST_NO_ROOM;
        if (state_reg == S_RDCAP) rbyte_reg <= ram_q;
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, SIZE_W'(free_now), count_reg[4:0], dropped_reg,
                       rec_out_reg.stamp, rec_out_reg.size, rbyte_reg, status_reg};

    `FRB_ASSERT(a_no_overlap, aclk, aresetn, !(put_open_reg && get_open_reg), "put and get both open")
    `FRB_ASSERT(a_count_max, aclk, aresetn, count_reg <= MAXF, "record count over capacity")
    `FRB_ASSERT(a_used_max, aclk, aresetn, used_reg <= BUF_SZ, "used bytes over capacity")
    `FRB_ASSERT(a_ready_idle, aclk, aresetn, $rose(m_tvalid) |-> !s_tready, "took input with result pending")
endmodule
`default_nettype wire

@@ hdl/frbdo_ram.sv @@
// Byte memory of the ring: one write port and one registered read port.
`default_nettype none
module frbdo_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire
